@@ design/sxr_pkg.sv @@
// ----------------------------------------------------------------------------
// sxr_pkg
// Types and constants shared by the nibblized SysEx frame receiver.
// ----------------------------------------------------------------------------
package sxr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int MAX_PAYLOAD = 2047;

  localparam int LEN_W   = 11;
  localparam int CNT_W   = 13;
  localparam int BCNT_W  = 7;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int HDR_LEN = 6;

  localparam logic [LEN_W-1:0] MAX_LEN =
    (MAX_PAYLOAD > 2047) ? 11'h7ff : LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] RAW_LEN =
    (BLOCK_BYTES > MAX_PAYLOAD) ? MAX_LEN : LEN_W'(BLOCK_BYTES);

  localparam logic [7:0] SYSEX_START = 8'hf0;
  localparam logic [7:0] SYSEX_END   = 8'hf7;

  localparam logic [7:0] CMD_PATCH = 8'h01;
  localparam logic [7:0] CMD_SEQ   = 8'h02;
  localparam logic [7:0] CMD_WAVE  = 8'h03;
  localparam logic [7:0] CMD_RAW   = 8'h40;

  localparam logic [1:0] KIND_PATCH = 2'd0;
  localparam logic [1:0] KIND_SEQ   = 2'd1;
  localparam logic [1:0] KIND_WAVE  = 2'd2;
  localparam logic [1:0] KIND_RAW   = 2'd3;

  localparam logic [1:0] REG_PATCH_LEN = 2'd0;
  localparam logic [1:0] REG_SEQ_LEN   = 2'd1;
  localparam logic [1:0] REG_WAVE_LEN  = 2'd2;
  localparam logic [1:0] REG_BLK_CNT   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_DATA    = 3'd3,
    PH_FOOTER  = 3'd4,
    PH_OK      = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]  patch_len;
    logic [LEN_W-1:0]  seq_len;
    logic [LEN_W-1:0]  wave_len;
    logic [BCNT_W-1:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic             byte_valid;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_index;
    logic [1:0]       target_kind;
    logic [7:0]       block_argument;
    logic [2:0]       rx_status;
    logic             frame_done;
  } result_t;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hf0;
      3'd1: b = 8'h00;
      3'd2: b = 8'h20;
      3'd3: b = 8'h77;
      3'd4: b = 8'h00;
      3'd5: b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] cmd);
    logic [1:0] k;
    case (cmd)
      CMD_SEQ:  k = KIND_SEQ;
      CMD_WAVE: k = KIND_WAVE;
      CMD_RAW:  k = KIND_RAW;
      default:  k = KIND_PATCH;
    endcase
    return k;
  endfunction

endpackage

@@ design/sxr_apb_regs.sv @@
// ----------------------------------------------------------------------------
// sxr_apb_regs
// APB register file: payload lengths and raw block count.
// ----------------------------------------------------------------------------
module sxr_apb_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sxr_pkg::ADDR_W-1:0] paddr,
  input  logic [sxr_pkg::DATA_W-1:0] pwdata,
  output logic [sxr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sxr_pkg::cfg_t              cfg
);

  sxr_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.patch_len   <= 11'd128;
      cfg_r.seq_len     <= 11'd128;
      cfg_r.wave_len    <= 11'd1024;
      cfg_r.block_count <= 7'd64;
    end else if (wr_en) begin
      case (reg_idx)
        sxr_pkg::REG_PATCH_LEN: cfg_r.patch_len <= pwdata[sxr_pkg::LEN_W-1:0];
        sxr_pkg::REG_SEQ_LEN:   cfg_r.seq_len   <= pwdata[sxr_pkg::LEN_W-1:0];
        sxr_pkg::REG_WAVE_LEN:  cfg_r.wave_len  <= pwdata[sxr_pkg::LEN_W-1:0];
        sxr_pkg::REG_BLK_CNT:   cfg_r.block_count <= pwdata[sxr_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sxr_pkg::REG_PATCH_LEN: prdata = 32'(cfg_r.patch_len);
      sxr_pkg::REG_SEQ_LEN:   prdata = 32'(cfg_r.seq_len);
      sxr_pkg::REG_WAVE_LEN:  prdata = 32'(cfg_r.wave_len);
      sxr_pkg::REG_BLK_CNT:   prdata = 32'(cfg_r.block_count);
      default:                prdata = '0;
    endcase
  end

endmodule

@@ design/sxr_parser.sv @@
// ----------------------------------------------------------------------------
// sxr_parser
// Frame state machine: header match, command, nibble join, checksum check.
// ----------------------------------------------------------------------------
module sxr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  sxr_pkg::cfg_t       cfg,
  output sxr_pkg::result_t    res
);

  sxr_pkg::phase_t                phase_r, phase_nxt;
  logic [sxr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic [3:0]                     hi_r, hi_nxt;
  logic [7:0]                     cmd_r, cmd_nxt;
  logic [7:0]                     arg_r, arg_nxt;
  logic [sxr_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [7:0]                     chk_r, chk_nxt;

  logic [sxr_pkg::CNT_W-2:0]      byte_idx;
  logic [sxr_pkg::CNT_W-1:0]      cnt_limit;
  logic [7:0]                     full;
  logic                           good;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sxr_pkg::PH_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      hi_r    <= '0;
      cmd_r   <= '0;
      arg_r   <= '0;
      len_r   <= '0;
      chk_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      cmd_r   <= cmd_nxt;
      arg_r   <= arg_nxt;
      len_r   <= len_nxt;
      chk_r   <= chk_nxt;
    end
  end

  assign byte_idx  = cnt_r[sxr_pkg::CNT_W-1:1];
  assign cnt_limit = {1'b0, len_r, 1'b0} + sxr_pkg::CNT_W'(2);
  assign full      = {hi_r, rx_byte[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    cmd_nxt   = cmd_r;
    arg_nxt   = arg_r;
    len_nxt   = len_r;
    chk_nxt   = chk_r;
    good      = 1'b0;
    res.byte_valid    = 1'b0;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.frame_done    = 1'b0;

    if (rx_byte == sxr_pkg::SYSEX_START) begin
      sum_nxt   = '0;
      cnt_nxt   = '0;
      phase_nxt = sxr_pkg::PH_HEADER;
    end

    case (phase_nxt)
      sxr_pkg::PH_HEADER: begin
        if (cnt_nxt < sxr_pkg::CNT_W'(sxr_pkg::HDR_LEN) &&
            sxr_pkg::header_byte(cnt_nxt[2:0]) == rx_byte) begin
          cnt_nxt = cnt_nxt + 1'b1;
          if (cnt_nxt >= sxr_pkg::CNT_W'(sxr_pkg::HDR_LEN)) begin
            phase_nxt = sxr_pkg::PH_COMMAND;
            cnt_nxt   = '0;
          end
        end else begin
          cmd_nxt   = '0;
          phase_nxt = sxr_pkg::PH_FOOTER;
        end
      end
      sxr_pkg::PH_COMMAND: begin
        if (cnt_nxt == '0) begin
          cmd_nxt = rx_byte;
          cnt_nxt = sxr_pkg::CNT_W'(1);
        end else begin
          arg_nxt   = rx_byte;
          cnt_nxt   = '0;
          phase_nxt = sxr_pkg::PH_DATA;
          case (cmd_nxt)
            sxr_pkg::CMD_PATCH: len_nxt = sxr_pkg::clamp_len(cfg.patch_len);
            sxr_pkg::CMD_SEQ:   len_nxt = sxr_pkg::clamp_len(cfg.seq_len);
            sxr_pkg::CMD_WAVE:  len_nxt = sxr_pkg::clamp_len(cfg.wave_len);
            sxr_pkg::CMD_RAW:   len_nxt = sxr_pkg::RAW_LEN;
            default:            phase_nxt = sxr_pkg::PH_FOOTER;
          endcase
        end
      end
      sxr_pkg::PH_DATA: begin
        if (cnt_r[0]) begin
          if (byte_idx < {1'b0, len_r}) begin
            sum_nxt           = sum_r + full;
            res.byte_valid    = 1'b1;
            res.payload_byte  = full;
            res.payload_index = byte_idx[sxr_pkg::LEN_W-1:0];
          end else begin
            chk_nxt = full;
          end
        end else begin
          hi_nxt = rx_byte[3:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt >= cnt_limit) begin
          phase_nxt = sxr_pkg::PH_FOOTER;
        end
      end
      sxr_pkg::PH_FOOTER: begin
        if (rx_byte == sxr_pkg::SYSEX_END && sum_r == chk_r) begin
          case (cmd_r)
            sxr_pkg::CMD_PATCH,
            sxr_pkg::CMD_SEQ,
            sxr_pkg::CMD_WAVE: good = 1'b1;
            sxr_pkg::CMD_RAW:  good = {1'b0, arg_r} < {2'b00, cfg.block_count};
            default:           good = 1'b0;
          endcase
        end
        phase_nxt      = good ? sxr_pkg::PH_OK : sxr_pkg::PH_ERROR;
        res.frame_done = 1'b1;
      end
      default: ;
    endcase

    res.target_kind    = sxr_pkg::kind_of(cmd_nxt);
    res.block_argument = arg_nxt;
    res.rx_status      = phase_nxt;
  end

endmodule

@@ design/nibble_sysex_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// nibble_sysex_frame_receiver
// Nibblized SysEx frame receiver with APB configuration.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per beat and returns exactly one result beat for each,
// in order. Unless in_stall is high, a new byte is taken every clock cycle.
// Its result appears on the outputs when the result register loads it;
// all parsing is combinational between input and result registers, so the
// frame state loop sets the rate at one byte per cycle while unstalled.
// in_stall rises only while a result waits in the result register and the
// next one is ready behind it. The user must write lengths and the block
// count over APB only while no frame is in flight; the block never checks it.
module nibble_sysex_frame_receiver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_byte_valid,
  output logic [7:0]                 out_payload_byte,
  output logic [10:0]                out_payload_index,
  output logic [1:0]                 out_target_kind,
  output logic [7:0]                 out_block_argument,
  output logic [2:0]                 out_rx_status,
  output logic                       out_frame_done,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sxr_pkg::ADDR_W-1:0] paddr,
  input  logic [sxr_pkg::DATA_W-1:0] pwdata,
  output logic [sxr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sxr_pkg::cfg_t    cfg;
  sxr_pkg::result_t res;
  sxr_pkg::result_t out_r;
  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             out_valid_r;
  logic             out_free;
  logic             advance;

  sxr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sxr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_valid     = out_r.byte_valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_payload_index  = out_r.payload_index;
  assign out_target_kind    = out_r.target_kind;
  assign out_block_argument = out_r.block_argument;
  assign out_rx_status      = out_r.rx_status;
  assign out_frame_done     = out_r.frame_done;

endmodule

@@ dv/nibble_sysex_frame_receiver_test.sv @@
// ----------------------------------------------------------------------------
// nibble_sysex_frame_receiver_test
// Self-checking bench for the nibblized SysEx frame receiver. A queue of MIDI
// bytes feeds a valid/stall driver; every accepted byte runs through a
// bit-accurate frame parser that queues the result beat it should cause, and
// a monitor compares each result beat field by field. Lengths and the block
// count are written and read back over APB between traffic phases, covering
// reset values, extremes and random small settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nibble_sysex_frame_receiver_test;
  import sxr_pkg::*;

  localparam logic [47:0] HDR_BYTES = 48'hf0_00_20_77_00_02;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_byte_valid;
  logic [7:0]          out_payload_byte;
  logic [10:0]         out_payload_index;
  logic [1:0]          out_target_kind;
  logic [7:0]          out_block_argument;
  logic [2:0]          out_rx_status;
  logic                out_frame_done;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  nibble_sysex_frame_receiver u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_valid     (out_byte_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_target_kind    (out_target_kind),
    .out_block_argument (out_block_argument),
    .out_rx_status      (out_rx_status),
    .out_frame_done     (out_frame_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // register mirror
  logic [LEN_W-1:0]  cfg_plen = 11'd128;
  logic [LEN_W-1:0]  cfg_slen = 11'd128;
  logic [LEN_W-1:0]  cfg_wlen = 11'd1024;
  logic [BCNT_W-1:0] cfg_bcnt = 7'd64;

  // parser state
  phase_t            ph = PH_IDLE;
  logic [CNT_W-1:0]  ncnt = '0;
  logic [7:0]        rsum = '0;
  logic [3:0]        hnib = '0;
  logic [7:0]        cmd = '0;
  logic [7:0]        arg = '0;
  logic [LEN_W-1:0]  elen = '0;
  logic [7:0]        rchk = '0;

  logic [7:0]  rx_byte_q [$];
  result_t     result_q [$];
  int          n_pushed = 0;
  int          n_err = 0;
  int unsigned cyc = 0;
  wire         quiet = (cyc >= 1000) && (cyc < 1600);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] hdr_at(input int k);
    return HDR_BYTES[47-8*k -: 8];
  endfunction

  function automatic logic [LEN_W-1:0] len_limit(input int len);
    return (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(len);
  endfunction

  function automatic bit cmd_known(input logic [7:0] c);
    return c == CMD_PATCH || c == CMD_SEQ || c == CMD_WAVE || c == CMD_RAW;
  endfunction

  function automatic result_t parse_rx_byte(input logic [7:0] b);
    result_t    r;
    int         idx;
    logic [7:0] full;
    bit         good;
    r = '0;
    if (b == SYSEX_START) begin
      rsum = '0;
      ncnt = '0;
      ph = PH_HEADER;
    end
    case (ph)
      PH_HEADER: begin
        if (ncnt < HDR_LEN && hdr_at(int'(ncnt)) == b) begin
          ncnt = ncnt + 1'b1;
          if (ncnt >= HDR_LEN) begin
            ph = PH_COMMAND;
            ncnt = '0;
          end
        end else begin
          cmd = '0;
          ph = PH_FOOTER;
        end
      end
      PH_COMMAND: begin
        if (ncnt == 0) begin
          cmd = b;
          ncnt = CNT_W'(1);
        end else begin
          arg = b;
          ncnt = '0;
          ph = PH_DATA;
          case (cmd)
            CMD_PATCH: elen = len_limit(int'(cfg_plen));
            CMD_SEQ:   elen = len_limit(int'(cfg_slen));
            CMD_WAVE:  elen = len_limit(int'(cfg_wlen));
            CMD_RAW:   elen = len_limit(BLOCK_BYTES);
            default:   ph = PH_FOOTER;
          endcase
        end
      end
      PH_DATA: begin
        idx = int'(ncnt) >> 1;
        if (ncnt[0]) begin
          full = {hnib, b[3:0]};
          if (idx < int'(elen)) begin
            rsum = rsum + full;
            r.byte_valid = 1'b1;
            r.payload_byte = full;
            r.payload_index = idx[LEN_W-1:0];
          end else begin
            rchk = full;
          end
        end else begin
          hnib = b[3:0];
        end
        ncnt = ncnt + 1'b1;
        if (int'(ncnt) >= (int'(elen) + 1) * 2) ph = PH_FOOTER;
      end
      PH_FOOTER: begin
        good = 1'b0;
        if (b == SYSEX_END && rsum == rchk && cmd_known(cmd)) begin
          if (cmd == CMD_RAW) good = ({1'b0, cfg_bcnt} > arg);
          else good = 1'b1;
        end
        ph = good ? PH_OK : PH_ERROR;
        r.frame_done = 1'b1;
      end
      default: ;
    endcase
    case (cmd)
      CMD_SEQ:  r.target_kind = KIND_SEQ;
      CMD_WAVE: r.target_kind = KIND_WAVE;
      CMD_RAW:  r.target_kind = KIND_RAW;
      default:  r.target_kind = KIND_PATCH;
    endcase
    r.block_argument = arg;
    r.rx_status = ph;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  task automatic push_b(input logic [7:0] b);
    rx_byte_q.push_back(b);
    n_pushed++;
  endtask

  function automatic logic [7:0] any_but_start();
    logic [7:0] b;
    do b = 8'($urandom); while (b == SYSEX_START);
    return b;
  endfunction

  // high nibble byte then low nibble byte; upper bits are usually clear
  function automatic logic [15:0] nibble_pair(input logic [7:0] v);
    logic [3:0] up_h, up_l;
    up_h = ($urandom_range(99) < 70) ? 4'h0 : 4'($urandom);
    up_l = ($urandom_range(99) < 70) ? 4'h0 : 4'($urandom);
    if ({up_h, v[7:4]} == SYSEX_START) up_h = 4'h0;
    if ({up_l, v[3:0]} == SYSEX_START) up_l = 4'h0;
    return {up_h, v[7:4], up_l, v[3:0]};
  endfunction

  task automatic push_frame(input logic [7:0] c, input logic [7:0] a, input int len,
                            input bit bad_sum, input bit bad_end, input int cut);
    logic [7:0]  fq [$];
    logic [7:0]  sum;
    logic [7:0]  pb;
    logic [15:0] np;
    sum = '0;
    for (int i = 0; i < HDR_LEN; i++) fq.push_back(hdr_at(i));
    fq.push_back(c);
    fq.push_back(a);
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom);
      sum = sum + pb;
      np = nibble_pair(pb);
      fq.push_back(np[15:8]);
      fq.push_back(np[7:0]);
    end
    if (bad_sum) sum = sum ^ (8'h01 << $urandom_range(7));
    np = nibble_pair(sum);
    fq.push_back(np[15:8]);
    fq.push_back(np[7:0]);
    if (bad_end) begin
      do pb = any_but_start(); while (pb == SYSEX_END);
      fq.push_back(pb);
    end else begin
      fq.push_back(SYSEX_END);
    end
    for (int i = 0; i < fq.size() && (cut < 0 || i < cut); i++) push_b(fq[i]);
  endtask

  task automatic push_traffic(input int n);
    int          start, sel, k, len;
    logic [7:0]  c, a, b;
    start = n_pushed;
    while (n_pushed - start < n) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) push_b(8'($urandom));
      end else if (sel < 14) begin
        k = $urandom_range(4);
        push_b(SYSEX_START);
        for (int i = 1; i <= k; i++) push_b(hdr_at(i));
        do b = 8'($urandom); while (b == hdr_at(k + 1) || b == SYSEX_START);
        push_b(b);
        push_b($urandom_range(1) ? SYSEX_END : any_but_start());
      end else if (sel < 20) begin
        for (int i = 0; i < HDR_LEN; i++) push_b(hdr_at(i));
        do c = 8'($urandom); while (cmd_known(c) || c == SYSEX_START);
        push_b(c);
        push_b(any_but_start());
        push_b($urandom_range(1) ? SYSEX_END : any_but_start());
      end else begin
        k = $urandom_range(99);
        if (k < 8) c = CMD_RAW;
        else if (k < 39) c = CMD_PATCH;
        else if (k < 70) c = CMD_SEQ;
        else c = CMD_WAVE;
        case (c)
          CMD_PATCH: len = int'(cfg_plen);
          CMD_SEQ:   len = int'(cfg_slen);
          CMD_WAVE:  len = int'(cfg_wlen);
          default:   len = BLOCK_BYTES;
        endcase
        if (c == CMD_RAW && $urandom_range(99) < 75) a = 8'($urandom_range(int'(cfg_bcnt) - 1));
        else a = any_but_start();
        k = $urandom_range(99) < 10 ? $urandom_range(1, 2 * len + 11) : -1;
        push_frame(c, a, len, $urandom_range(99) < 15, $urandom_range(99) < 8, k);
      end
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_BLK_CNT) ? 32'h7f : 32'h7ff;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PATCH_LEN: cfg_plen = val[LEN_W-1:0];
      REG_SEQ_LEN:   cfg_slen = val[LEN_W-1:0];
      REG_WAVE_LEN:  cfg_wlen = val[LEN_W-1:0];
      default:       cfg_bcnt = val[BCNT_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (val & mask)) begin
      $error("readback reg %0d: expected %0h actual %0h", idx, val & mask, prdata & mask);
      n_err++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int p, input int s, input int w, input int bc);
    cfg_write(REG_PATCH_LEN, p);
    cfg_write(REG_SEQ_LEN, s);
    cfg_write(REG_WAVE_LEN, w);
    cfg_write(REG_BLK_CNT, bc);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (rx_byte_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  // ---------------- driver / monitor ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) result_q.push_back(parse_rx_byte(in_rx_byte));
      if (!in_valid || !in_stall) begin
        if (rx_byte_q.size() != 0 && (quiet || $urandom_range(99) >= 34)) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 34);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_err++;
      end else begin
        want = result_q.pop_front();
        if (out_byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0h actual %0h", want.byte_valid, out_byte_valid);
          n_err++;
        end
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h actual %0h", want.payload_byte, out_payload_byte);
          n_err++;
        end
        if (out_payload_index !== want.payload_index) begin
          $error("payload_index: expected %0d actual %0d", want.payload_index,
                 out_payload_index);
          n_err++;
        end
        if (out_target_kind !== want.target_kind) begin
          $error("target_kind: expected %0d actual %0d", want.target_kind, out_target_kind);
          n_err++;
        end
        if (out_block_argument !== want.block_argument) begin
          $error("block_argument: expected %0h actual %0h", want.block_argument,
                 out_block_argument);
          n_err++;
        end
        if (out_rx_status !== want.rx_status) begin
          $error("rx_status: expected %0d actual %0d", want.rx_status, out_rx_status);
          n_err++;
        end
        if (out_frame_done !== want.frame_done) begin
          $error("frame_done: expected %0h actual %0h", want.frame_done, out_frame_done);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- phases ----------------

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: idle noise, broken header, unknown command, raw blocks, cut frames
    push_b(8'h00); push_b(8'h7f); push_b(8'h80); push_b(8'hff); push_b(SYSEX_END);
    push_b(SYSEX_START); push_b(8'h11); push_b(SYSEX_END);
    for (int i = 0; i < HDR_LEN; i++) push_b(hdr_at(i));
    push_b(8'h05); push_b(8'h00); push_b(SYSEX_END);
    push_frame(CMD_RAW, 8'd63, BLOCK_BYTES, 1'b0, 1'b0, -1);
    push_frame(CMD_RAW, 8'd64, BLOCK_BYTES, 1'b0, 1'b0, -1);
    push_frame(CMD_PATCH, 8'h12, 128, 1'b0, 1'b0, 120);
    push_frame(CMD_WAVE, 8'h34, 1024, 1'b0, 1'b0, 60);
    push_frame(CMD_SEQ, 8'h56, 128, 1'b0, 1'b0, 40);
    wait_drained();

    set_config(1, 2, 3, 1);
    // payload nibbles carried by status bytes, F7 among them
    for (int i = 0; i < HDR_LEN; i++) push_b(hdr_at(i));
    push_b(CMD_PATCH); push_b(8'h5a); push_b(8'h8f); push_b(SYSEX_END);
    push_b(8'h0f); push_b(8'h07); push_b(SYSEX_END);
    push_frame(CMD_SEQ, 8'h00, 2, 1'b1, 1'b0, -1);
    push_frame(CMD_WAVE, 8'hff, 3, 1'b0, 1'b1, -1);
    push_frame(CMD_RAW, 8'd0, BLOCK_BYTES, 1'b0, 1'b0, -1);
    push_traffic(120);
    wait_drained();

    set_config($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(1, 127));
    push_traffic(150);
    wait_drained();

    set_config(2047, 2047, 2047, 127);
    push_frame(CMD_PATCH, 8'h7f, 2047, 1'b0, 1'b0, 40);
    push_frame(CMD_SEQ, 8'h01, 2047, 1'b0, 1'b0, 40);
    push_frame(CMD_WAVE, 8'h02, 2047, 1'b0, 1'b0, 30);
    push_frame(CMD_RAW, 8'd126, BLOCK_BYTES, 1'b0, 1'b0, -1);
    wait_drained();

    set_config(3, 1, 2, 1);
    push_traffic(100);
    wait_drained();

    set_config($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 24),
               $urandom_range(1, 127));
    push_traffic(100);
    wait_drained();

    repeat (10) @(posedge clk);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
